// ===== rtl/core/pllt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pooled linked list table package
// Command and result word types, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package pllt_pkg;

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_SEARCH = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_QUERY  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    STAT_DONE      = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_REM_HEAD  = 3'd4,
    STAT_REM_LAST  = 3'd5,
    STAT_REM_MID   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_LINK,
    S_WALK,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] key;
    logic [31:0] payload;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] item_data;
    logic [6:0]  free_slots;
  } result_t;

endpackage

// ===== rtl/core/pooled_linked_list_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pooled linked list table
// Ordered singly linked list of key and payload entries held in a fixed pool.
// ----------------------------------------------------------------------------
// A command word is taken on a rising edge with start high and busy low. busy
// stays high while the sequencer works; exactly one result word follows, shown
// for one cycle with done high. The receiver cannot stall, so nothing waits.
// The slot memories share one read address; the sequencer works as follows:
//   append:          scans up from slot 0 to the lowest free slot, then links
//                    it at the tail (answered from idle if the pool is full)
//   search, delete:  walk from the head to the first match or the list end
//                    (answered from idle on an empty list)
//   clear:           marks every slot free, one slot mark per cycle
//   free query:      answered from the idle state
// After reset a clearing pass frees every slot; busy is high throughout and
// no command is taken until it ends.
// ----------------------------------------------------------------------------
module pooled_linked_list_table #(
  parameter int SLOTS        = 64,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pllt_pkg::cmd_t    cmd,
  output logic             done,
  output pllt_pkg::result_t result
);
  import pllt_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // Slot memories: used mark, link word {has_next, next}, key, payload.
  logic                    used_mem [SLOTS];
  logic [AW:0]             link_mem [SLOTS];
  logic [KEY_BITS-1:0]     key_mem  [SLOTS];
  logic [PAYLOAD_BITS-1:0] pay_mem  [SLOTS];

  logic                    used_q;
  logic [AW:0]             link_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  state_t            state, state_next;
  logic [AW-1:0]     cur, rd_addr;
  logic [AW-1:0]     prev, prev_next;
  logic              prev_valid, prev_valid_next;
  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     tail, tail_next;
  logic              nonempty, nonempty_next;
  logic [AW-1:0]     alloc, alloc_next;
  logic [CW-1:0]     free_cnt, free_cnt_next;
  logic [AW-1:0]     clr, clr_next;
  cmd_t              cmd_r, cmd_r_next;
  logic              done_next;
  result_t           result_next;

  logic                    used_we, used_wd;
  logic [AW-1:0]           used_wa;
  logic                    link_we;
  logic [AW-1:0]           link_wa;
  logic [AW:0]             link_wd;
  logic                    ent_we;
  logic [PAYLOAD_BITS+31:0] pay_in_ext;
  logic [PAYLOAD_BITS+31:0] pay_out_ext;
  logic                    key_hit;

  function automatic logic [6:0] free_field(input logic [CW-1:0] v);
    logic [CW+6:0] ext;
    ext = {7'b0, v};
    return ext[6:0];
  endfunction

  assign pay_in_ext  = {{PAYLOAD_BITS{1'b0}}, cmd_r.payload};
  assign pay_out_ext = {32'b0, pay_q};
  assign key_hit     = (key_q == cmd_r.key[KEY_BITS-1:0]);
  assign busy        = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    used_q <= used_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_q <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[cur] <= cmd_r.key[KEY_BITS-1:0];
      pay_mem[cur] <= pay_in_ext[PAYLOAD_BITS-1:0];
    end
    key_q <= key_mem[rd_addr];
    pay_q <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      clr        <= '0;
      head       <= '0;
      tail       <= '0;
      nonempty   <= 1'b0;
      prev_valid <= 1'b0;
      free_cnt   <= CW'(SLOTS);
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      clr        <= clr_next;
      head       <= head_next;
      tail       <= tail_next;
      nonempty   <= nonempty_next;
      prev_valid <= prev_valid_next;
      free_cnt   <= free_cnt_next;
      done       <= done_next;
    end
    cur    <= rd_addr;
    prev   <= prev_next;
    alloc  <= alloc_next;
    cmd_r  <= cmd_r_next;
    result <= result_next;
  end

  always_comb begin
    state_next      = state;
    rd_addr         = cur;
    prev_next       = prev;
    prev_valid_next = prev_valid;
    head_next       = head;
    tail_next       = tail;
    nonempty_next   = nonempty;
    alloc_next      = alloc;
    free_cnt_next   = free_cnt;
    clr_next        = clr;
    cmd_r_next      = cmd_r;
    used_we         = 1'b0;
    used_wa         = cur;
    used_wd         = 1'b0;
    link_we         = 1'b0;
    link_wa         = cur;
    link_wd         = '0;
    ent_we          = 1'b0;
    done_next       = 1'b0;
    result_next     = result;
    result_next.item_data  = '0;
    result_next.free_slots = free_field(free_cnt);

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_r_next = cmd;
          case (cmd.mode)
            MODE_APPEND: begin
              if (free_cnt == '0) begin
                done_next          = 1'b1;
                result_next.status = STAT_FULL;
              end else begin
                rd_addr    = '0;
                state_next = S_SCAN;
              end
            end
            MODE_SEARCH, MODE_DELETE: begin
              if (!nonempty) begin
                done_next          = 1'b1;
                result_next.status = STAT_NOT_FOUND;
              end else begin
                rd_addr         = head;
                prev_valid_next = 1'b0;
                state_next      = S_WALK;
              end
            end
            MODE_CLEAR: begin
              clr_next   = '0;
              state_next = S_CLEAR;
            end
            default: begin
              done_next          = 1'b1;
              result_next.status = STAT_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // A free slot is known to exist, so the scan stops inside the pool.
        if (!used_q) begin
          used_we    = 1'b1;
          used_wd    = 1'b1;
          ent_we     = 1'b1;
          link_we    = 1'b1;
          link_wd    = '0;
          alloc_next = cur;
          state_next = S_LINK;
        end else begin
          rd_addr = cur + AW'(1);
        end
      end

      S_LINK: begin
        if (nonempty) begin
          link_we = 1'b1;
          link_wa = tail;
          link_wd = {1'b1, alloc};
        end else begin
          head_next = alloc;
        end
        nonempty_next          = 1'b1;
        tail_next              = alloc;
        free_cnt_next          = free_cnt - CW'(1);
        done_next              = 1'b1;
        result_next.status     = STAT_DONE;
        result_next.free_slots = free_field(free_cnt - CW'(1));
        state_next             = S_IDLE;
      end

      S_WALK: begin
        if (key_hit) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (cmd_r.mode == MODE_SEARCH) begin
            result_next.status    = STAT_FOUND;
            result_next.item_data = pay_out_ext[31:0];
          end else begin
            used_we                = 1'b1;
            used_wd                = 1'b0;
            free_cnt_next          = free_cnt + CW'(1);
            result_next.free_slots = free_field(free_cnt + CW'(1));
            if (!prev_valid) begin
              head_next          = link_q[AW] ? link_q[AW-1:0] : '0;
              nonempty_next      = link_q[AW];
              result_next.status = STAT_REM_HEAD;
            end else begin
              // The predecessor takes over the removed entry's link.
              link_we = 1'b1;
              link_wa = prev;
              link_wd = link_q;
              if (link_q[AW]) begin
                result_next.status = STAT_REM_MID;
              end else begin
                tail_next          = prev;
                result_next.status = STAT_REM_LAST;
              end
            end
          end
        end else if (link_q[AW]) begin
          prev_next       = cur;
          prev_valid_next = 1'b1;
          rd_addr         = link_q[AW-1:0];
        end else begin
          done_next          = 1'b1;
          result_next.status = STAT_NOT_FOUND;
          state_next         = S_IDLE;
        end
      end

      S_INIT, S_CLEAR: begin
        used_we  = 1'b1;
        used_wa  = clr;
        used_wd  = 1'b0;
        clr_next = clr + AW'(1);
        if (clr == AW'(SLOTS - 1)) begin
          head_next     = '0;
          nonempty_next = 1'b0;
          free_cnt_next = CW'(SLOTS);
          state_next    = S_IDLE;
          if (state == S_CLEAR) begin
            done_next              = 1'b1;
            result_next.status     = STAT_DONE;
            result_next.free_slots = free_field(CW'(SLOTS));
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/pllt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pooled linked list table checker
// Port-level properties of the command and result words, bound to the top.
// ----------------------------------------------------------------------------
module pllt_checker #(
  parameter int SLOTS = 64
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input pllt_pkg::cmd_t    cmd,
  input logic              done,
  input pllt_pkg::result_t result
);
  import pllt_pkg::*;

  // An accepted word is either still being worked on or answered at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word neither busy nor answered");

  // Data is returned only by a successful search.
  a_data_only_found: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STAT_FOUND) |-> (result.item_data == 32'd0))
    else $error("item data set on a result other than found");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= STAT_REM_MID))
    else $error("result status out of range");

  // The free count never exceeds the pool size.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> ((SLOTS > 127) || (int'(result.free_slots) <= SLOTS)))
    else $error("free slot count above pool size");

  // A result can only follow an accepted word or a busy period.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result word without a command");

endmodule

bind pooled_linked_list_table pllt_checker #(.SLOTS(SLOTS)) u_pllt_checker (.*);

// ===== tb/pllt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pooled linked list table checker
// Watches the command and result channels, keeps its own copy of the slot
// pool and the list, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module pllt_tb_checker #(
  parameter int SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  pllt_pkg::cmd_t    cmd,
  input  logic              done,
  input  pllt_pkg::result_t result,
  output int                errors,
  output int                pending,
  output int                checked
);
  import pllt_pkg::*;

  localparam int REPORT_LIMIT = 10;

  bit          slot_taken [SLOTS];
  int          link       [SLOTS];
  bit          link_valid [SLOTS];
  logic [63:0] slot_key   [SLOTS];
  logic [31:0] slot_data  [SLOTS];
  int          first_slot;
  bit          list_live;

  result_t awaited_results [$];
  int      fault_count;
  int      result_count;

  function automatic int free_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_taken[i]) n++;
    end
    return n;
  endfunction

  function automatic void release_slot(input int s);
    slot_taken[s] = 1'b0;
    link[s]       = 0;
    link_valid[s] = 1'b0;
    slot_key[s]   = '0;
    slot_data[s]  = '0;
  endfunction

  // Walks from the head, at most SLOTS steps, for the first entry with this key.
  function automatic bit find_entry(input logic [63:0] k, output int at, output int prev,
                                    output bit has_prev);
    int cur;
    bit valid;
    cur      = first_slot;
    valid    = list_live;
    at       = 0;
    prev     = 0;
    has_prev = 1'b0;
    for (int n = 0; n < SLOTS && valid; n++) begin
      if (slot_key[cur] == k) begin
        at = cur;
        return 1'b1;
      end
      prev     = cur;
      has_prev = 1'b1;
      valid    = link_valid[cur];
      cur      = link[cur];
    end
    return 1'b0;
  endfunction

  function automatic result_t apply_command(input cmd_t c);
    result_t r;
    int      s;
    int      at;
    int      prev;
    int      tail;
    bit      has_prev;
    r.status    = STAT_DONE;
    r.item_data = '0;
    case (c.mode)
      MODE_APPEND: begin
        s = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!slot_taken[i]) s = i;
        end
        if (s < 0) begin
          r.status = STAT_FULL;
        end else begin
          slot_taken[s] = 1'b1;
          slot_key[s]   = c.key;
          slot_data[s]  = c.payload;
          link[s]       = 0;
          link_valid[s] = 1'b0;
          if (!list_live) begin
            first_slot = s;
            list_live  = 1'b1;
          end else begin
            tail = first_slot;
            for (int n = 0; n < SLOTS && link_valid[tail]; n++) tail = link[tail];
            link[tail]       = s;
            link_valid[tail] = 1'b1;
          end
        end
      end
      MODE_SEARCH: begin
        if (find_entry(c.key, at, prev, has_prev)) begin
          r.status    = STAT_FOUND;
          r.item_data = slot_data[at];
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      MODE_DELETE: begin
        if (!find_entry(c.key, at, prev, has_prev)) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          if (!has_prev) begin
            // A sole entry also leaves through here, emptying the list.
            r.status   = STAT_REM_HEAD;
            list_live  = link_valid[at];
            first_slot = link_valid[at] ? link[at] : 0;
          end else begin
            r.status         = link_valid[at] ? STAT_REM_MID : STAT_REM_LAST;
            link[prev]       = link[at];
            link_valid[prev] = link_valid[at];
          end
          release_slot(at);
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) release_slot(i);
        first_slot = 0;
        list_live  = 1'b0;
      end
      default: begin
      end
    endcase
    r.free_slots = 7'(free_count());
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) release_slot(i);
      first_slot   = 0;
      list_live    = 1'b0;
      awaited_results.delete();
      fault_count  = 0;
      result_count = 0;
      errors  <= 0;
      pending <= 0;
      checked <= 0;
    end else begin
      if (done === 1'b1) begin
        result_count++;
        if (awaited_results.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("%t: result word with nothing awaited: status %0d data %h free %0d",
                     $realtime, result.status, result.item_data, result.free_slots);
        end else begin
          want = awaited_results.pop_front();
          if (result.status !== want.status || result.item_data !== want.item_data ||
              result.free_slots !== want.free_slots) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
              $display("%t: result %0d expected status %0d data %h free %0d, got %0d %h %0d",
                       $realtime, result_count, want.status, want.item_data, want.free_slots,
                       result.status, result.item_data, result.free_slots);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) awaited_results.push_back(apply_command(cmd));
      errors  <= fault_count;
      pending <= awaited_results.size();
      checked <= result_count;
    end
  end

endmodule

// ===== tb/pooled_linked_list_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pooled linked list table testbench
// Drives directed and random command words into the table, with random idle
// bursts, while a separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module pooled_linked_list_table_tb;
  import pllt_pkg::*;

  localparam int          SLOTS            = 64;
  localparam int          ITEMS            = 500;
  localparam int          TAIL_CALM        = 80;
  localparam int          SETTLE_CYCLES    = 100;
  localparam int          WATCHDOG_LIMIT   = 2000;
  localparam int          KEY_POOL         = 16;
  localparam logic [2:0]  MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  MODE_SPARE_LAST  = 3'd7;
  localparam logic [63:0] TAG_KEY          = "GATK";

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    done;
  result_t result;

  int          errors;
  int          pending;
  int          checked;
  int          sent;
  int          per_mode [8];
  int          quiet_cycles;
  bit          idling_on;
  logic [63:0] key_pool [KEY_POOL];

  always #5 clk = ~clk;

  pooled_linked_list_table #(
    .SLOTS(SLOTS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  pllt_tb_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result),
    .errors (errors),
    .pending(pending),
    .checked(checked)
  );

  // The count restarts on every accepted word in either direction.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles without progress", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic hold_off(input int n);
    cmd_t noise;
    noise.mode    = 3'($urandom_range(7));
    noise.key     = {$urandom, $urandom};
    noise.payload = $urandom;
    start <= 1'b0;
    cmd   <= noise;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic issue(input logic [2:0] m, input logic [63:0] k, input logic [31:0] p);
    cmd_t c;
    c.mode    = m;
    c.key     = k;
    c.payload = p;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
    per_mode[m]++;
    if (idling_on && ITEMS - sent > TAIL_CALM && $urandom_range(99) < 30)
      hold_off($urandom_range(1, 9));
  endtask

  function automatic logic [63:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(KEY_POOL - 1)];
    return {$urandom, $urandom};
  endfunction

  // Styles: 0 grows the list, 1 shrinks it, 2 keeps it roughly level.
  task automatic random_command(input int style);
    int         r;
    int         app_w;
    int         srch_w;
    logic [2:0] m;
    app_w  = (style == 0) ? 50 : (style == 1) ? 18 : 33;
    srch_w = (style == 0) ? 20 : (style == 1) ? 25 : 28;
    r      = $urandom_range(99);
    if (r < 2)
      m = MODE_CLEAR;
    else if (r < 6)
      m = MODE_QUERY;
    else if (r < 9)
      m = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    else if (r - 9 < app_w)
      m = MODE_APPEND;
    else if (r - 9 < app_w + srch_w)
      m = MODE_SEARCH;
    else
      m = MODE_DELETE;
    issue(m, pick_key(), $urandom);
  endtask

  initial begin
    int style;
    int span;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = TAG_KEY;
    idling_on   = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Empty table, then a short list with a duplicate key, unlinked from every position.
    issue(MODE_QUERY, '0, '0);
    issue(MODE_SEARCH, '0, '0);
    issue(MODE_DELETE, '1, '0);
    issue(MODE_APPEND, '0, '0);
    issue(MODE_APPEND, '1, '1);
    issue(MODE_APPEND, TAG_KEY, 32'h0000_0001);
    issue(MODE_APPEND, '0, 32'hA5A5_5A5A);
    issue(MODE_SEARCH, '0, '1);
    issue(MODE_SEARCH, '1, '0);
    issue(MODE_SEARCH, 64'h8000_0000_0000_0001, '0);
    issue(MODE_DELETE, '1, '0);
    issue(MODE_DELETE, '0, '0);
    issue(MODE_SEARCH, '0, '0);
    issue(MODE_DELETE, '0, '0);
    issue(MODE_DELETE, TAG_KEY, '0);
    issue(MODE_DELETE, TAG_KEY, '0);
    issue(3'd5, '1, '1);
    issue(3'd6, TAG_KEY, 32'h1234_5678);
    issue(3'd7, '0, '0);
    issue(MODE_APPEND, TAG_KEY, 32'hDEAD_BEEF);
    issue(MODE_APPEND, 64'h5555_AAAA_5555_AAAA, 32'h8000_0000);
    issue(MODE_CLEAR, '1, '1);
    issue(MODE_QUERY, '0, '0);
    drain();

    // Fill the pool past full, then walk the long list.
    for (int i = 0; i < 70; i++) issue(MODE_APPEND, pick_key(), $urandom);
    for (int i = 0; i < 24; i++)
      issue($urandom_range(1) ? MODE_SEARCH : MODE_DELETE, pick_key(), $urandom);
    drain();

    while (sent < ITEMS) begin
      style     = $urandom_range(2);
      span      = $urandom_range(15, 40);
      idling_on = ($urandom_range(3) != 0);
      key_pool[$urandom_range(3, KEY_POOL - 1)] = {$urandom, $urandom};
      for (int i = 0; i < span && sent < ITEMS; i++) random_command(style);
      if ($urandom_range(1)) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d commands: %0d append, %0d search, %0d delete, %0d clear,",
             sent, per_mode[MODE_APPEND], per_mode[MODE_SEARCH], per_mode[MODE_DELETE],
             per_mode[MODE_CLEAR]);
    $display("%0d free query and %0d spare mode; %0d result words were compared.",
             per_mode[MODE_QUERY], per_mode[5] + per_mode[6] + per_mode[7], checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
